// ===== src/ddshd_pkg.sv =====
// Shared types, codes and constants of the DDS header decoder.
package ddshd_pkg;

  localparam logic [31:0] DDS_MAGIC     = 32'h2053_4444;
  localparam logic [31:0] HDR_SIZE      = 32'd124;
  localparam logic [31:0] PF_FOURCC     = 32'h0000_0004;
  localparam logic [31:0] CAPS2_CUBEMAP = 32'h0000_0200;
  localparam logic [31:0] CAPS2_VOLUME  = 32'h0020_0000;
  localparam logic [31:0] CC_DXT1       = 32'h3154_5844;
  localparam logic [31:0] CC_DXT3       = 32'h3354_5844;
  localparam logic [31:0] CC_DXT5       = 32'h3554_5844;
  localparam logic [31:0] MASK_B0       = 32'h0000_00FF;
  localparam logic [31:0] MASK_B1       = 32'h0000_FF00;
  localparam logic [31:0] MASK_B2       = 32'h00FF_0000;
  localparam logic [31:0] MASK_B3       = 32'hFF00_0000;
  localparam logic [31:0] BITS_32       = 32'd32;
  localparam logic [31:0] BITS_24       = 32'd24;
  localparam logic [31:0] BITS_8        = 32'd8;

  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAGIC  = 6'd0;
  localparam logic [POS_W-1:0] POS_SIZE   = 6'd1;
  localparam logic [POS_W-1:0] POS_HEIGHT = 6'd3;
  localparam logic [POS_W-1:0] POS_WIDTH  = 6'd4;
  localparam logic [POS_W-1:0] POS_DEPTH  = 6'd6;
  localparam logic [POS_W-1:0] POS_MIPS   = 6'd7;
  localparam logic [POS_W-1:0] POS_FLAGS  = 6'd20;
  localparam logic [POS_W-1:0] POS_FOURCC = 6'd21;
  localparam logic [POS_W-1:0] POS_BITS   = 6'd22;
  localparam logic [POS_W-1:0] POS_MASK_R = 6'd23;
  localparam logic [POS_W-1:0] POS_MASK_G = 6'd24;
  localparam logic [POS_W-1:0] POS_MASK_B = 6'd25;
  localparam logic [POS_W-1:0] POS_MASK_A = 6'd26;
  localparam logic [POS_W-1:0] POS_CAPS2  = 6'd28;
  localparam logic [POS_W-1:0] POS_LAST   = 6'd31;
  localparam logic [POS_W-1:0] POS_MAX    = 6'd63;

  localparam logic [2:0] CH_NONE  = 3'd0;
  localparam logic [2:0] CH_ONE   = 3'd1;
  localparam logic [2:0] CH_THREE = 3'd3;
  localparam logic [2:0] CH_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_SIZE   = 2'd2,
    ERR_FORMAT = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    FMT_NONE = 4'd0,
    FMT_DXT1 = 4'd1,
    FMT_DXT3 = 4'd2,
    FMT_DXT5 = 4'd3,
    FMT_BGRA = 4'd4,
    FMT_RGBA = 4'd5,
    FMT_RGB  = 4'd6,
    FMT_BGR  = 4'd7,
    FMT_LUM  = 4'd8
  } fmt_t;

  typedef enum logic [1:0] {
    KIND_FLAT   = 2'd0,
    KIND_VOLUME = 2'd1,
    KIND_CUBE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_HOLD
  } back_state_t;

  typedef struct packed {
    err_t        err;
    fmt_t        fmt;
    logic [2:0]  chans;
    kind_t       kind;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] depth;
    logic [31:0] mips;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

endpackage

// ===== src/ddshd_ifs.sv =====
// Handshake interfaces for header words and decoded results.
interface ddshd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic        first_word;

  modport source(output valid, output header_word, output first_word, input ready);
  modport sink(input valid, input header_word, input first_word, output ready);
endinterface

interface ddshd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  error_code;
  logic [3:0]  texture_format;
  logic [2:0]  channel_count;
  logic [1:0]  texture_kind;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [31:0] image_depth;
  logic [31:0] extra_mip_levels;
  logic [31:0] base_image_bytes;

  modport source(output valid, output error_code, output texture_format,
                 output channel_count, output texture_kind, output image_width,
                 output image_height, output image_depth, output extra_mip_levels,
                 output base_image_bytes, input ready);
  modport sink(input valid, input error_code, input texture_format,
               input channel_count, input texture_kind, input image_width,
               input image_height, input image_depth, input extra_mip_levels,
               input base_image_bytes, output ready);
endinterface

// ===== src/dds_header_decoder.sv =====
// Top level of the DDS header decoder.
// The hdr channel takes the 128-byte header of a DDS file as 32 words, one
// per transaction; first_word marks the magic word and restarts the count.
// Words past the thirty-second are ignored until the next first_word.
// The res channel gives one transaction per header, after its last word,
// holding the error code, format, channel count, kind, sizes, extra mip
// levels and the byte size of the base image.
// The front end accepts one word per cycle, save that the last word of a
// header waits while the queue is full, and keeps the header fields in
// registers. On the last word it classifies the header and pushes it into a
// two-entry queue. The back end takes one entry at a time, multiplies the
// size operands in state BK_MUL, scales the product in BK_SCALE and
// registers the result, then holds it in BK_HOLD until res accepts it; it
// takes no new entry before then.
// When res is stalled the result register holds, the queue fills, and then
// the last word of a further header waits; all other words still flow.
// A synchronous reset clears the word count, the held fields and the queue.
module dds_header_decoder (
  input  logic        clk,
  input  logic        rst,
  ddshd_in_if.sink    hdr,
  ddshd_out_if.source res
);

  ddshd_pkg::push_req_t     push_req;
  ddshd_pkg::queue_status_t q_status;
  ddshd_pkg::job_t          head;
  logic                     pop;

  ddshd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .hdr      (hdr),
    .q_status (q_status),
    .push_req (push_req)
  );

  ddshd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  ddshd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .res      (res)
  );

endmodule

// ===== src/ddshd_front.sv =====
// Front end: takes header words, holds the fields and classifies the header.
module ddshd_front (
  input  logic                     clk,
  input  logic                     rst,
  ddshd_in_if.sink                 hdr,
  input  ddshd_pkg::queue_status_t q_status,
  output ddshd_pkg::push_req_t     push_req
);

  logic [ddshd_pkg::POS_W-1:0] word_position;
  logic [ddshd_pkg::POS_W-1:0] pos;
  logic        magic_good;
  logic        size_good;
  logic [31:0] held_height;
  logic [31:0] held_width;
  logic [31:0] held_depth;
  logic [31:0] held_mip_count;
  logic [31:0] held_format_flags;
  logic [31:0] held_fourcc;
  logic [31:0] held_bit_count;
  logic [31:0] held_masks [4];
  logic [31:0] held_caps_two;
  logic        accept;
  logic [32:0] blocks_x;
  logic [32:0] blocks_y;
  ddshd_pkg::fmt_t  fmt;
  logic [2:0]       chans;
  ddshd_pkg::job_t  job;

  assign pos = hdr.first_word ? ddshd_pkg::POS_MAGIC : word_position;
  assign hdr.ready = !(q_status.full && word_position == ddshd_pkg::POS_LAST);
  assign accept = hdr.valid && hdr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position     <= ddshd_pkg::POS_MAGIC;
      magic_good        <= 1'b0;
      size_good         <= 1'b0;
      held_height       <= '0;
      held_width        <= '0;
      held_depth        <= '0;
      held_mip_count    <= '0;
      held_format_flags <= '0;
      held_fourcc       <= '0;
      held_bit_count    <= '0;
      held_masks[0]     <= '0;
      held_masks[1]     <= '0;
      held_masks[2]     <= '0;
      held_masks[3]     <= '0;
      held_caps_two     <= '0;
    end else if (accept) begin
      word_position <= (pos < ddshd_pkg::POS_MAX) ? pos + 1'b1 : ddshd_pkg::POS_MAX;
      case (pos)
        ddshd_pkg::POS_MAGIC:  magic_good        <= (hdr.header_word == ddshd_pkg::DDS_MAGIC);
        ddshd_pkg::POS_SIZE:   size_good         <= (hdr.header_word == ddshd_pkg::HDR_SIZE);
        ddshd_pkg::POS_HEIGHT: held_height       <= hdr.header_word;
        ddshd_pkg::POS_WIDTH:  held_width        <= hdr.header_word;
        ddshd_pkg::POS_DEPTH:  held_depth        <= hdr.header_word;
        ddshd_pkg::POS_MIPS:   held_mip_count    <= hdr.header_word;
        ddshd_pkg::POS_FLAGS:  held_format_flags <= hdr.header_word;
        ddshd_pkg::POS_FOURCC: held_fourcc       <= hdr.header_word;
        ddshd_pkg::POS_BITS:   held_bit_count    <= hdr.header_word;
        ddshd_pkg::POS_MASK_R: held_masks[0]     <= hdr.header_word;
        ddshd_pkg::POS_MASK_G: held_masks[1]     <= hdr.header_word;
        ddshd_pkg::POS_MASK_B: held_masks[2]     <= hdr.header_word;
        ddshd_pkg::POS_MASK_A: held_masks[3]     <= hdr.header_word;
        ddshd_pkg::POS_CAPS2:  held_caps_two     <= hdr.header_word;
        default: ;
      endcase
    end
  end

  always_comb begin
    fmt   = ddshd_pkg::FMT_NONE;
    chans = ddshd_pkg::CH_NONE;
    if ((held_format_flags & ddshd_pkg::PF_FOURCC) != '0) begin
      if (held_fourcc == ddshd_pkg::CC_DXT1) begin
        fmt = ddshd_pkg::FMT_DXT1; chans = ddshd_pkg::CH_THREE;
      end else if (held_fourcc == ddshd_pkg::CC_DXT3) begin
        fmt = ddshd_pkg::FMT_DXT3; chans = ddshd_pkg::CH_FOUR;
      end else if (held_fourcc == ddshd_pkg::CC_DXT5) begin
        fmt = ddshd_pkg::FMT_DXT5; chans = ddshd_pkg::CH_FOUR;
      end
    end else if (held_bit_count == ddshd_pkg::BITS_32 && held_masks[0] == ddshd_pkg::MASK_B2
                 && held_masks[1] == ddshd_pkg::MASK_B1 && held_masks[2] == ddshd_pkg::MASK_B0
                 && held_masks[3] == ddshd_pkg::MASK_B3) begin
      fmt = ddshd_pkg::FMT_BGRA; chans = ddshd_pkg::CH_FOUR;
    end else if (held_bit_count == ddshd_pkg::BITS_32 && held_masks[0] == ddshd_pkg::MASK_B0
                 && held_masks[1] == ddshd_pkg::MASK_B1 && held_masks[2] == ddshd_pkg::MASK_B2
                 && held_masks[3] == ddshd_pkg::MASK_B3) begin
      fmt = ddshd_pkg::FMT_RGBA; chans = ddshd_pkg::CH_FOUR;
    end else if (held_bit_count == ddshd_pkg::BITS_24 && held_masks[0] == ddshd_pkg::MASK_B0
                 && held_masks[1] == ddshd_pkg::MASK_B1
                 && held_masks[2] == ddshd_pkg::MASK_B2) begin
      fmt = ddshd_pkg::FMT_RGB; chans = ddshd_pkg::CH_THREE;
    end else if (held_bit_count == ddshd_pkg::BITS_24 && held_masks[0] == ddshd_pkg::MASK_B2
                 && held_masks[1] == ddshd_pkg::MASK_B1
                 && held_masks[2] == ddshd_pkg::MASK_B0) begin
      fmt = ddshd_pkg::FMT_BGR; chans = ddshd_pkg::CH_THREE;
    end else if (held_bit_count == ddshd_pkg::BITS_8) begin
      fmt = ddshd_pkg::FMT_LUM; chans = ddshd_pkg::CH_ONE;
    end
  end

  assign blocks_x = ({1'b0, held_width} + 33'd3) >> 2;
  assign blocks_y = ({1'b0, held_height} + 33'd3) >> 2;

  always_comb begin
    job = '0;
    if (!magic_good) begin
      job.err = ddshd_pkg::ERR_MAGIC;
    end else if (!size_good) begin
      job.err = ddshd_pkg::ERR_SIZE;
    end else begin
      job.err   = (fmt == ddshd_pkg::FMT_NONE) ? ddshd_pkg::ERR_FORMAT : ddshd_pkg::ERR_OK;
      job.fmt   = fmt;
      job.chans = chans;
      if ((held_caps_two & ddshd_pkg::CAPS2_CUBEMAP) != '0) begin
        job.kind = ddshd_pkg::KIND_CUBE;
      end else if ((held_caps_two & ddshd_pkg::CAPS2_VOLUME) != '0 && held_depth != '0) begin
        job.kind = ddshd_pkg::KIND_VOLUME;
      end else begin
        job.kind = ddshd_pkg::KIND_FLAT;
      end
      job.width  = held_width;
      job.height = held_height;
      job.depth  = (held_depth != '0) ? held_depth : 32'd1;
      job.mips   = (held_mip_count != '0) ? held_mip_count - 32'd1 : 32'd0;
      if (fmt == ddshd_pkg::FMT_DXT1 || fmt == ddshd_pkg::FMT_DXT3
          || fmt == ddshd_pkg::FMT_DXT5) begin
        job.mul_a = blocks_x[31:0];
        job.mul_b = blocks_y[31:0];
      end else begin
        job.mul_a = held_width;
        job.mul_b = held_height;
      end
    end
  end

  assign push_req.push = accept && pos == ddshd_pkg::POS_LAST;
  assign push_req.job  = job;

endmodule

// ===== src/ddshd_queue.sv =====
// Two-entry queue of classified headers between the front and back ends.
module ddshd_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  ddshd_pkg::push_req_t     push_req,
  input  logic                     pop,
  output ddshd_pkg::job_t          head,
  output ddshd_pkg::queue_status_t q_status
);

  ddshd_pkg::job_t entries [ddshd_pkg::Q_DEPTH];
  logic [ddshd_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [ddshd_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [ddshd_pkg::Q_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign q_status.full  = (count == ddshd_pkg::Q_CNT_W'(ddshd_pkg::Q_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push = push_req.push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/ddshd_back.sv =====
// Back end: computes the base image size and presents the result.
module ddshd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  ddshd_pkg::job_t          head,
  input  ddshd_pkg::queue_status_t q_status,
  output logic                     pop,
  ddshd_out_if.source              res
);

  ddshd_pkg::back_state_t state;
  ddshd_pkg::back_state_t state_next;
  ddshd_pkg::job_t job;
  logic [31:0] prod;
  logic [31:0] bytes_next;
  logic        load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddshd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    res.valid  = 1'b0;
    case (state)
      ddshd_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = ddshd_pkg::BK_MUL;
        end
      end
      ddshd_pkg::BK_MUL: begin
        state_next = ddshd_pkg::BK_SCALE;
      end
      ddshd_pkg::BK_SCALE: begin
        load_out   = 1'b1;
        state_next = ddshd_pkg::BK_HOLD;
      end
      ddshd_pkg::BK_HOLD: begin
        res.valid = 1'b1;
        if (res.ready) begin
          state_next = ddshd_pkg::BK_IDLE;
        end
      end
      default: state_next = ddshd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    case (job.fmt)
      ddshd_pkg::FMT_DXT1:                     bytes_next = prod << 3;
      ddshd_pkg::FMT_DXT3, ddshd_pkg::FMT_DXT5: bytes_next = prod << 4;
      ddshd_pkg::FMT_BGRA, ddshd_pkg::FMT_RGBA: bytes_next = prod << 2;
      ddshd_pkg::FMT_RGB, ddshd_pkg::FMT_BGR:   bytes_next = prod + (prod << 1);
      ddshd_pkg::FMT_LUM:                      bytes_next = prod;
      default:                                 bytes_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (state == ddshd_pkg::BK_MUL) begin
      prod <= 32'(job.mul_a * job.mul_b);
    end
    if (load_out) begin
      res.error_code       <= job.err;
      res.texture_format   <= job.fmt;
      res.channel_count    <= job.chans;
      res.texture_kind     <= job.kind;
      res.image_width      <= job.width;
      res.image_height     <= job.height;
      res.image_depth      <= job.depth;
      res.extra_mip_levels <= job.mips;
      res.base_image_bytes <= bytes_next;
    end
  end

endmodule
